/* sv/swarq_pkg.sv */
// Shared types and constants for the sliding window ARQ sender.
package swarq_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned WIN_W = 6;
  localparam int unsigned STAMP_W = 16;
  localparam int unsigned ACK_W = 9;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDLE_W = 3;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_ACK = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [WIN_W-1:0] WINDOW_SIZE_RST = 6'd4;
  localparam logic [STAMP_W-1:0] TIMEOUT_RST = 16'd100;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_FINISH = 1'b1;
  localparam logic [BYTE_W-1:0] FINISH_CHAR = 8'h46;
  localparam logic [IDLE_W-1:0] IDLE_FINISH = 3'd5;
  localparam logic [IDLE_W-1:0] IDLE_MAX = 3'd7;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_ACK,
    CMD_TICK
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
    logic [BYTE_W-1:0] data_byte;
    logic [ACK_W-1:0] ack_number;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_END,
    BK_FIN
  } back_state_e;

endpackage

/* sv/swarq_front.sv */
// Front end: accepts transactions, classifies them and queues commands for the back end.
module swarq_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             action_i,
  input  logic [7:0]             data_byte_i,
  input  logic [8:0]             ack_number_i,
  output logic                   cmd_vld_o,
  output swarq_pkg::cmd_t        cmd_o,
  input  logic                   cmd_pop_i
);
  import swarq_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       keep;
  logic       push;
  logic       pop;
  cmd_t       cmd_new;

  always_comb begin
    keep = 1'b1;
    cmd_new.op = CMD_LOAD;
    cmd_new.data_byte = data_byte_i;
    cmd_new.ack_number = ack_number_i;
    case (action_i)
      ACT_LOAD: cmd_new.op = CMD_LOAD;
      ACT_ACK:  cmd_new.op = CMD_ACK;
      ACT_TICK: cmd_new.op = CMD_TICK;
      default:  keep = 1'b0;
    endcase
  end

  assign busy = (count_q == 2'd2);
  assign push = start && !busy && keep;
  assign pop = cmd_pop_i && (count_q != 2'd0);
  assign cmd_vld_o = (count_q != 2'd0);
  assign cmd_o = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

/* sv/swarq_back.sv */
// Back end: segment store, window state and the tick walk that emits segments.
module swarq_back #(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned MAX_WINDOW = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [5:0]             window_size_i,
  input  logic [15:0]            timeout_i,
  input  logic                   cmd_vld_i,
  input  swarq_pkg::cmd_t        cmd_i,
  output logic                   cmd_pop_o,
  output logic                   result_valid_o,
  output logic                   kind_o,
  output logic [7:0]             seq_number_o,
  output logic [7:0]             payload_o,
  output logic                   last_o
);
  import swarq_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned POS_W = (CNT_W > 10) ? CNT_W : 10;
  localparam logic [WIN_W-1:0] MaxWin = WIN_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_SEGMENTS);

  logic [BYTE_W-1:0]    data_mem [MAX_SEGMENTS];
  logic [STAMP_W:0]     stat_mem [MAX_SEGMENTS];

  back_state_e          state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [ACK_W-1:0]     left_q, left_d;
  logic [POS_W-1:0]     right_q, right_d;
  logic [STAMP_W-1:0]   tick_q, tick_d;
  logic [IDLE_W-1:0]    idle_q, idle_d;
  logic [WIN_W-1:0]     j_q, j_d;
  logic                 s1_vld_q, s1_vld_d;
  logic [POS_W-1:0]     s1_idx_q, s1_idx_d;
  logic                 hold_vld_q, hold_vld_d;
  logic [BYTE_W-1:0]    hold_seq_q, hold_seq_d;
  logic [BYTE_W-1:0]    hold_pay_q, hold_pay_d;
  logic                 sent_any_q, sent_any_d;
  logic                 res_vld_q, res_vld_d;
  logic                 res_kind_q, res_kind_d;
  logic [BYTE_W-1:0]    res_seq_q, res_seq_d;
  logic [BYTE_W-1:0]    res_pay_q, res_pay_d;
  logic                 res_last_q, res_last_d;

  logic [BYTE_W-1:0]    data_rd_q;
  logic [STAMP_W:0]     stat_rd_q;

  logic                 data_we;
  logic                 stat_we;
  logic [ADDR_W-1:0]    wr_addr;
  logic [STAMP_W:0]     stat_wdata;
  logic [ADDR_W-1:0]    rd_addr;

  logic [WIN_W-1:0]     win;
  logic [POS_W-1:0]     walk_pos;
  logic                 walk_ok;
  logic [POS_W-1:0]     ack_top;
  logic [STAMP_W-1:0]   age;
  logic                 do_send;
  logic [IDLE_W-1:0]    idle_next;
  logic                 fin;

  always_comb begin
    if (window_size_i == '0) begin
      win = WIN_W'(1);
    end else if (window_size_i > MaxWin) begin
      win = MaxWin;
    end else begin
      win = window_size_i;
    end
  end

  assign walk_pos = POS_W'(left_q) + POS_W'(j_q);
  assign walk_ok = (j_q < win) && (walk_pos <= right_q) && (walk_pos < POS_W'(cnt_q));
  assign rd_addr = walk_pos[ADDR_W-1:0];
  assign ack_top = POS_W'(cmd_i.ack_number) + POS_W'(win) - POS_W'(1);
  assign age = tick_q - stat_rd_q[STAMP_W-1:0];
  assign do_send = !stat_rd_q[STAMP_W] || (age >= timeout_i);
  assign idle_next = sent_any_q ? IDLE_W'(1) : ((idle_q < IDLE_MAX) ? idle_q + IDLE_W'(1) : idle_q);
  assign fin = (POS_W'(left_q) == right_q) && (idle_next == IDLE_FINISH);
  assign cmd_pop_o = (state_q == BK_IDLE) && cmd_vld_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_vld_i && cmd_i.op == CMD_TICK) begin
          state_d = BK_WALK;
        end
      end
      BK_WALK: begin
        if (!walk_ok && !s1_vld_q) begin
          state_d = BK_END;
        end
      end
      BK_END:  state_d = fin ? BK_FIN : BK_IDLE;
      BK_FIN:  state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    left_d = left_q;
    right_d = right_q;
    tick_d = tick_q;
    idle_d = idle_q;
    j_d = j_q;
    s1_vld_d = 1'b0;
    s1_idx_d = walk_pos;
    hold_vld_d = hold_vld_q;
    hold_seq_d = hold_seq_q;
    hold_pay_d = hold_pay_q;
    sent_any_d = sent_any_q;
    res_vld_d = 1'b0;
    res_kind_d = KIND_DATA;
    res_seq_d = hold_seq_q;
    res_pay_d = hold_pay_q;
    res_last_d = 1'b0;
    data_we = 1'b0;
    stat_we = 1'b0;
    wr_addr = cnt_q[ADDR_W-1:0];
    stat_wdata = {1'b0, tick_q};
    case (state_q)
      BK_IDLE: begin
        if (cmd_vld_i) begin
          case (cmd_i.op)
            CMD_LOAD: begin
              if (cnt_q < MaxCnt) begin
                data_we = 1'b1;
                stat_we = 1'b1;
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            CMD_ACK: begin
              left_d = cmd_i.ack_number;
              if (ack_top < POS_W'(cnt_q)) begin
                right_d = ack_top;
              end
            end
            CMD_TICK: begin
              tick_d = tick_q + STAMP_W'(1);
              j_d = '0;
              hold_vld_d = 1'b0;
              sent_any_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      BK_WALK: begin
        if (walk_ok) begin
          s1_vld_d = 1'b1;
          j_d = j_q + WIN_W'(1);
        end
        if (s1_vld_q && do_send) begin
          stat_we = 1'b1;
          wr_addr = s1_idx_q[ADDR_W-1:0];
          stat_wdata = {1'b1, tick_q};
          res_vld_d = hold_vld_q;
          hold_vld_d = 1'b1;
          hold_seq_d = s1_idx_q[BYTE_W-1:0];
          hold_pay_d = data_rd_q;
          sent_any_d = 1'b1;
        end
      end
      BK_END: begin
        idle_d = idle_next;
        res_vld_d = hold_vld_q;
        res_last_d = !fin;
      end
      BK_FIN: begin
        res_vld_d = 1'b1;
        res_kind_d = KIND_FINISH;
        res_seq_d = '0;
        res_pay_d = FINISH_CHAR;
        res_last_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q <= '0;
      left_q <= '0;
      right_q <= POS_W'(WINDOW_SIZE_RST) - POS_W'(1);
      tick_q <= '0;
      idle_q <= '0;
      j_q <= '0;
      s1_vld_q <= 1'b0;
      hold_vld_q <= 1'b0;
      sent_any_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      left_q <= left_d;
      right_q <= right_d;
      tick_q <= tick_d;
      idle_q <= idle_d;
      j_q <= j_d;
      s1_vld_q <= s1_vld_d;
      hold_vld_q <= hold_vld_d;
      sent_any_q <= sent_any_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= s1_idx_d;
    hold_seq_q <= hold_seq_d;
    hold_pay_q <= hold_pay_d;
    res_kind_q <= res_kind_d;
    res_seq_q <= res_seq_d;
    res_pay_q <= res_pay_d;
    res_last_q <= res_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[wr_addr] <= cmd_i.data_byte;
    end
    data_rd_q <= data_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stat_we) begin
      stat_mem[wr_addr] <= stat_wdata;
    end
    stat_rd_q <= stat_mem[rd_addr];
  end

  assign result_valid_o = res_vld_q;
  assign kind_o = res_kind_q;
  assign seq_number_o = res_seq_q;
  assign payload_o = res_pay_q;
  assign last_o = res_last_q;

endmodule

/* sv/sliding_window_arq_sender.sv */
// Top level of the sliding window ARQ sender: configuration registers, front end, back end.
//
//   Channel   Handshake               Ports
//   command   start & !busy           action_i, data_byte_i, ack_number_i
//   result    result_valid_o strobe   kind_o, seq_number_o, payload_o, last_o
//   config    cfg_we_i                cfg_index_i, cfg_wdata_i
//
// A load or an ack is handled in the back-end idle state once it leaves the two-entry command queue.
// A tick runs the walk state, then the end state, and the finish state when a finish
// marker follows; the walk visits one window slot per cycle through the registered
// segment store port.
// Results appear at most one per cycle; the receiver cannot stall them.
// After reset the window is 0 to 3 and no clearing pass is needed.
// busy is high only while the command queue is full.
module sliding_window_arq_sender #(
  parameter int unsigned MAX_SEGMENTS = 256,
  parameter int unsigned MAX_WINDOW = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         action_i,
  input  logic [7:0]                         data_byte_i,
  input  logic [8:0]                         ack_number_i,
  input  logic                               cfg_we_i,
  input  logic [swarq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [swarq_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                               result_valid_o,
  output logic                               kind_o,
  output logic [7:0]                         seq_number_o,
  output logic [7:0]                         payload_o,
  output logic                               last_o
);
  import swarq_pkg::*;

  logic [WIN_W-1:0]   win_size_q, win_size_d;
  logic [STAMP_W-1:0] timeout_q, timeout_d;
  logic               cmd_vld;
  cmd_t               cmd;
  logic               cmd_pop;

  always_comb begin
    win_size_d = win_size_q;
    timeout_d = timeout_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW_SIZE: win_size_d = cfg_wdata_i[WIN_W-1:0];
        CFG_TIMEOUT:     timeout_d = cfg_wdata_i[STAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WINDOW_SIZE_RST;
      timeout_q <= TIMEOUT_RST;
    end else begin
      win_size_q <= win_size_d;
      timeout_q <= timeout_d;
    end
  end

  swarq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .ack_number_i (ack_number_i),
    .cmd_vld_o    (cmd_vld),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  swarq_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .window_size_i  (win_size_q),
    .timeout_i      (timeout_q),
    .cmd_vld_i      (cmd_vld),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .seq_number_o   (seq_number_o),
    .payload_o      (payload_o),
    .last_o         (last_o)
  );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the sliding window ARQ sender with a behavioral predictor.
`timescale 1ns / 100ps

module testbench;
  import swarq_pkg::*;

  localparam int unsigned SEGMENTS = 256;
  localparam int unsigned WINDOW_CAP = 32;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    logic       kind;
    logic [7:0] seq;
    logic [7:0] payload;
    logic       last;
  } frame_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            action_i = ACT_LOAD;
  logic [7:0]            data_byte_i = '0;
  logic [8:0]            ack_number_i = '0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_WINDOW_SIZE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  result_valid_o;
  logic                  kind_o;
  logic [7:0]            seq_number_o;
  logic [7:0]            payload_o;
  logic                  last_o;

  logic [7:0]  seg_data [SEGMENTS];
  logic        seg_sent [SEGMENTS];
  logic        seg_armed [SEGMENTS];
  logic [15:0] seg_stamp [SEGMENTS];
  logic [8:0]  seg_total;
  logic [8:0]  win_base;
  logic [8:0]  win_top;
  logic [15:0] tick_count;
  logic [2:0]  quiet_ticks;
  logic [5:0]  window_cfg;
  logic [15:0] timeout_cfg;

  frame_t      outgoing_frames [$];
  int unsigned error_count = 0;
  bit          gaps_on = 1'b1;

  sliding_window_arq_sender u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .data_byte_i    (data_byte_i),
    .ack_number_i   (ack_number_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .seq_number_o   (seq_number_o),
    .payload_o      (payload_o),
    .last_o         (last_o)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic int unsigned effective_window();
    if (window_cfg == 0) return 1;
    if (window_cfg > WINDOW_CAP) return WINDOW_CAP;
    return window_cfg;
  endfunction

  task automatic predict_frames(input logic [1:0] act, input logic [7:0] byte_in,
                                input logic [8:0] ack_in);
    int unsigned span;
    int unsigned reach;
    int unsigned idx;
    int unsigned j;
    int unsigned emitted;
    logic [15:0] age;
    frame_t      frame;
    span = effective_window();
    reach = 0;
    emitted = 0;
    case (act)
      ACT_LOAD: begin
        if (seg_total < SEGMENTS) begin
          seg_data[seg_total] = byte_in;
          seg_sent[seg_total] = 1'b0;
          seg_armed[seg_total] = 1'b0;
          seg_total++;
        end
      end
      ACT_ACK: begin
        win_base = ack_in;
        if (ack_in + span - 1 < seg_total) win_top = 9'(ack_in + span - 1);
      end
      ACT_TICK: begin
        tick_count++;
        while (reach < span && win_base + reach <= win_top && win_base + reach < seg_total) begin
          reach++;
        end
        for (j = 0; j < reach; j++) begin
          idx = win_base + j;
          age = tick_count - seg_stamp[idx];
          if (seg_armed[idx] && age >= timeout_cfg) begin
            seg_sent[idx] = 1'b0;
            seg_armed[idx] = 1'b0;
          end
        end
        for (j = 0; j < reach; j++) begin
          idx = win_base + j;
          if (!seg_sent[idx]) begin
            frame = '{kind: KIND_DATA, seq: idx[7:0], payload: seg_data[idx], last: 1'b0};
            outgoing_frames.push_back(frame);
            seg_stamp[idx] = tick_count;
            seg_armed[idx] = 1'b1;
            seg_sent[idx] = 1'b1;
            quiet_ticks = '0;
            emitted++;
          end
        end
        if (quiet_ticks < IDLE_MAX) quiet_ticks++;
        if (win_base == win_top && quiet_ticks == IDLE_FINISH) begin
          frame = '{kind: KIND_FINISH, seq: 8'd0, payload: FINISH_CHAR, last: 1'b0};
          outgoing_frames.push_back(frame);
          emitted++;
        end
        if (emitted > 0) outgoing_frames[outgoing_frames.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic issue_command(input logic [1:0] act, input logic [7:0] byte_in,
                               input logic [8:0] ack_in);
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 65) len = 0;
    else if (roll < 95) len = $urandom_range(1, 3);
    else len = $urandom_range(8, 40);
    if (len > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (len - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    action_i <= act;
    data_byte_i <= byte_in;
    ack_number_i <= ack_in;
    do @(posedge clk_i); while (busy);
    predict_frames(act, byte_in, ack_in);
  endtask

  task automatic wait_for_frames(input int unsigned extra);
    int unsigned waited;
    @(negedge clk_i);
    start <= 1'b0;
    waited = 0;
    while (outgoing_frames.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (outgoing_frames.size() != 0) begin
      report_mismatch($sformatf("%0d frames never arrived, oldest seq %0d",
                                outgoing_frames.size(), outgoing_frames[0].seq));
      outgoing_frames.delete();
    end
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    wait_for_frames(SETTLE_CYCLES);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WINDOW_SIZE) window_cfg = value[5:0];
    else timeout_cfg = value;
  endtask

  always @(posedge clk_i) begin : result_check
    frame_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (outgoing_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected frame kind %0d seq %0d payload %02h last %0d",
                                  kind_o, seq_number_o, payload_o, last_o));
      end else begin
        want = outgoing_frames.pop_front();
        if ({kind_o, seq_number_o, payload_o, last_o} !== want) begin
          report_mismatch($sformatf(
            "got kind %0d seq %0d payload %02h last %0d, expected %0d %0d %02h %0d",
            kind_o, seq_number_o, payload_o, last_o,
            want.kind, want.seq, want.payload, want.last));
        end
      end
    end
  end

  task automatic test_directed();
    issue_command(ACT_LOAD, 8'h00, 9'h1FF);
    issue_command(ACT_LOAD, 8'hFF, 9'h000);
    issue_command(ACT_LOAD, 8'hA5, 9'h0AA);
    issue_command(ACT_LOAD, 8'h5A, 9'h155);
    issue_command(ACT_LOAD, 8'h01, 9'h100);
    issue_command(ACT_LOAD, 8'h80, 9'h001);
    issue_command(ACT_UNUSED, 8'hFF, 9'h1FF);
    issue_command(ACT_TICK, 8'h00, 9'h000);
    issue_command(ACT_ACK, 8'hFF, 9'd2);
    issue_command(ACT_TICK, 8'hFF, 9'h1FF);
    issue_command(ACT_ACK, 8'h00, 9'd5);
    repeat (6) issue_command(ACT_TICK, 8'h00, 9'h000);
    issue_command(ACT_ACK, 8'h00, 9'h1FF);
    issue_command(ACT_TICK, 8'h00, 9'h000);
    issue_command(ACT_ACK, 8'h00, 9'd256);
    issue_command(ACT_TICK, 8'h00, 9'h000);
    issue_command(ACT_ACK, 8'h00, 9'd0);
    issue_command(ACT_TICK, 8'h00, 9'h000);
  endtask

  task automatic test_config_extremes();
    logic [CFG_DATA_W-1:0] win_values [4];
    logic [CFG_DATA_W-1:0] limit_values [4];
    int unsigned p;
    win_values = '{16'd0, 16'd63, 16'hFFE0, 16'd1};
    limit_values = '{16'd0, 16'd1, 16'hFFFF, 16'd2};
    for (p = 0; p < 4; p++) begin
      write_register(CFG_WINDOW_SIZE, win_values[p]);
      write_register(CFG_TIMEOUT, limit_values[p]);
      repeat (3) issue_command(ACT_LOAD, 8'($urandom), 9'($urandom));
      issue_command(ACT_ACK, 8'($urandom), win_base);
      repeat (3) issue_command(ACT_TICK, 8'($urandom), 9'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    int unsigned roll;
    logic [8:0] ack;
    for (phase = 0; phase < 5; phase++) begin
      gaps_on = (phase != 2);
      roll = $urandom_range(0, 9);
      write_register(CFG_WINDOW_SIZE, (roll < 2) ? CFG_DATA_W'(roll * 32) :
                                      CFG_DATA_W'($urandom_range(1, 12)));
      roll = $urandom_range(0, 9);
      write_register(CFG_TIMEOUT, (roll == 0) ? CFG_DATA_W'($urandom) :
                                  CFG_DATA_W'($urandom_range(1, 10)));
      for (n = 0; n < 24; n++) begin
        if ($urandom_range(0, 99) < 5) wait_for_frames(0);
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          issue_command(ACT_LOAD, 8'($urandom), 9'($urandom));
        end else if (roll < 55) begin
          if ($urandom_range(0, 99) < 85) begin
            ack = 9'($urandom_range(win_base, (seg_total > win_base) ? seg_total : win_base));
          end else begin
            ack = 9'($urandom_range(0, seg_total));
          end
          issue_command(ACT_ACK, 8'($urandom), ack);
        end else if (roll < 95) begin
          issue_command(ACT_TICK, 8'($urandom), 9'($urandom));
        end else if (roll < 97) begin
          issue_command(ACT_UNUSED, 8'($urandom), 9'($urandom));
        end else begin
          issue_command(ACT_ACK, 8'($urandom), 9'($urandom));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_store_full();
    write_register(CFG_WINDOW_SIZE, 16'd32);
    write_register(CFG_TIMEOUT, 16'hFFFF);
    while (seg_total < SEGMENTS) issue_command(ACT_LOAD, 8'($urandom), 9'($urandom));
    repeat (3) issue_command(ACT_LOAD, 8'($urandom), 9'($urandom));
    issue_command(ACT_ACK, 8'($urandom), 9'd224);
    issue_command(ACT_TICK, 8'($urandom), 9'($urandom));
    issue_command(ACT_ACK, 8'($urandom), 9'd255);
    repeat (7) issue_command(ACT_TICK, 8'($urandom), 9'($urandom));
    issue_command(ACT_ACK, 8'($urandom), 9'd256);
    issue_command(ACT_TICK, 8'($urandom), 9'($urandom));
  endtask

  initial begin
    for (int i = 0; i < SEGMENTS; i++) begin
      seg_data[i] = '0;
      seg_sent[i] = 1'b0;
      seg_armed[i] = 1'b0;
      seg_stamp[i] = '0;
    end
    seg_total = '0;
    win_base = '0;
    win_top = 9'(WINDOW_SIZE_RST) - 9'd1;
    tick_count = '0;
    quiet_ticks = '0;
    window_cfg = WINDOW_SIZE_RST;
    timeout_cfg = TIMEOUT_RST;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_extremes();
    test_random_traffic();
    test_store_full();
    wait_for_frames(SETTLE_CYCLES);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sliding_window_arq_sender.f */
sv/swarq_pkg.sv
sv/swarq_front.sv
sv/swarq_back.sv
sv/sliding_window_arq_sender.sv
dv/testbench.sv
